// File: sv/sofq_pkg.sv
// ----------------------------------------------------------------------------
// sofq_pkg
// Shared types and constants for the stack or FIFO queue block.
// ----------------------------------------------------------------------------
package sofq_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_WIDTH_DEF = 64;

  localparam int ID_W   = 31;
  localparam int PAY_W  = 64;
  localparam int POS_W  = 4;
  localparam int CNT_W  = 5;

  localparam int CQ_DEPTH = 2;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_PULL  = 2'd1,
    ACT_FIND  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [ID_W-1:0]     item_id;
    logic [PAY_W-1:0]    payload;
    logic                payload_present;
  } in_word_t;

  typedef struct packed {
    logic                success;
    logic [ID_W-1:0]     out_id;
    logic [PAY_W-1:0]    out_payload;
    logic [POS_W-1:0]    position;
    logic [CNT_W-1:0]    entry_count;
    logic [ID_W-1:0]     next_id;
  } out_word_t;

  typedef struct packed {
    action_t             action;
    logic                push_ok;
    logic [ID_W-1:0]     item_id;
    logic [PAY_W-1:0]    payload;
  } cmd_t;

endpackage

// File: sv/sofq_front.sv
// ----------------------------------------------------------------------------
// sofq_front
// Input stage: registers each accepted word and classifies it as a command.
// ----------------------------------------------------------------------------
module sofq_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sofq_pkg::in_word_t in_word,
  output logic            cmd_valid,
  input  logic            cmd_ready,
  output sofq_pkg::cmd_t  cmd
);
  import sofq_pkg::*;

  logic cmd_valid_r;
  cmd_t cmd_r;
  cmd_t cmd_nxt;

  assign in_ready  = !cmd_valid_r || cmd_ready;
  assign cmd_valid = cmd_valid_r;
  assign cmd       = cmd_r;

  always_comb begin
    cmd_nxt.action  = in_word.action;
    cmd_nxt.push_ok = (in_word.item_id != '0) && in_word.payload_present;
    cmd_nxt.item_id = in_word.item_id;
    cmd_nxt.payload = in_word.payload;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
    end else if (in_ready) begin
      cmd_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// File: sv/sofq_cmd_queue.sv
// ----------------------------------------------------------------------------
// sofq_cmd_queue
// Short command queue between the input stage and the execution engine.
// ----------------------------------------------------------------------------
module sofq_cmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  sofq_pkg::cmd_t wr_cmd,
  output logic           rd_valid,
  input  logic           rd_ready,
  output sofq_pkg::cmd_t rd_cmd
);
  import sofq_pkg::*;

  localparam int QPW = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int QFW = $clog2(CQ_DEPTH + 1);

  cmd_t           q_r [CQ_DEPTH];
  logic [QPW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QFW-1:0] fill_r, fill_nxt;
  logic           do_wr, do_rd;

  assign wr_ready = (fill_r != QFW'(CQ_DEPTH));
  assign rd_valid = (fill_r != '0);
  assign rd_cmd   = q_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(CQ_DEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(CQ_DEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
    end
    if (do_wr && !do_rd) begin
      fill_nxt = fill_r + QFW'(1);
    end else if (do_rd && !do_wr) begin
      fill_nxt = fill_r - QFW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

// File: sv/sofq_back.sv
// ----------------------------------------------------------------------------
// sofq_back
// Execution engine: entry memory, ring pointers, search walk and result word.
// ----------------------------------------------------------------------------
module sofq_back #(
  parameter int DEPTH         = sofq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = sofq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  sofq_pkg::cmd_t               cmd,
  output logic                         out_valid,
  input  logic                         out_ready,
  output sofq_pkg::out_word_t          out_word,
  output logic [$clog2(DEPTH+1)-1:0]   held_count
);
  import sofq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PULL = 5'b00010,
    S_SCAN = 5'b00100,
    S_PEEK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  function automatic logic [PW-1:0] slot_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [PW-1:0] slot_dec(input logic [PW-1:0] p);
    return (p == '0) ? PW'(DEPTH - 1) : p - PW'(1);
  endfunction

  logic [ID_W-1:0]          id_mem  [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [DEPTH];
  logic [ID_W-1:0]          rd_id_r;
  logic [PAYLOAD_WIDTH-1:0] rd_pay_r;

  state_t                   state_r, state_nxt;
  logic [PW-1:0]            newest_r, newest_nxt;
  logic [PW-1:0]            oldest_r, oldest_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [PW-1:0]            scan_r, scan_nxt;
  logic [CW-1:0]            k_r, k_nxt;
  logic                     lifo_r;
  logic                     res_success_r, res_success_nxt;
  logic [ID_W-1:0]          res_id_r, res_id_nxt;
  logic [PAYLOAD_WIDTH-1:0] res_pay_r, res_pay_nxt;
  logic [CW-1:0]            res_pos_r, res_pos_nxt;
  logic [ID_W-1:0]          find_id_r, find_id_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_word_t                out_word_r, out_word_nxt;

  logic                     mem_we;
  logic                     rd_en;
  logic [PW-1:0]            rd_addr;
  logic [PW-1:0]            slot;
  logic                     load_out;

  assign cmd_ready  = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_word   = out_word_r;
  assign held_count = count_r;

  always_comb begin
    state_nxt       = state_r;
    newest_nxt      = newest_r;
    oldest_nxt      = oldest_r;
    count_nxt       = count_r;
    scan_nxt        = scan_r;
    k_nxt           = k_r;
    res_success_nxt = res_success_r;
    res_id_nxt      = res_id_r;
    res_pay_nxt     = res_pay_r;
    res_pos_nxt     = res_pos_r;
    find_id_nxt     = find_id_r;
    mem_we          = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = '0;
    slot            = '0;
    load_out        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          res_success_nxt = 1'b0;
          res_id_nxt      = '0;
          res_pay_nxt     = '0;
          res_pos_nxt     = '0;
          find_id_nxt     = cmd.item_id;
          k_nxt           = '0;
          state_nxt       = S_PEEK;
          unique case (cmd.action)
            ACT_PUSH: begin
              if (cmd.push_ok && (count_r != CW'(DEPTH))) begin
                mem_we          = 1'b1;
                newest_nxt      = slot_inc(newest_r);
                count_nxt       = count_r + CW'(1);
                res_success_nxt = 1'b1;
              end
            end
            ACT_PULL: begin
              if (count_r != '0) begin
                if (lifo_r) begin
                  slot       = slot_dec(newest_r);
                  newest_nxt = slot;
                end else begin
                  slot       = oldest_r;
                  oldest_nxt = slot_inc(oldest_r);
                end
                rd_en           = 1'b1;
                rd_addr         = slot;
                count_nxt       = count_r - CW'(1);
                res_success_nxt = 1'b1;
                state_nxt       = S_PULL;
              end
            end
            ACT_FIND: begin
              if (count_r != '0) begin
                slot      = lifo_r ? oldest_r : slot_dec(newest_r);
                rd_en     = 1'b1;
                rd_addr   = slot;
                scan_nxt  = slot;
                state_nxt = S_SCAN;
              end
            end
            ACT_CLEAR: begin
              newest_nxt      = '0;
              oldest_nxt      = '0;
              count_nxt       = '0;
              res_success_nxt = 1'b1;
            end
          endcase
        end
      end
      S_PULL: begin
        res_id_nxt  = rd_id_r;
        res_pay_nxt = rd_pay_r;
        state_nxt   = S_PEEK;
      end
      S_SCAN: begin
        if (rd_id_r == find_id_r) begin
          res_success_nxt = 1'b1;
          res_pos_nxt     = k_r;
          state_nxt       = S_PEEK;
        end else if ((k_r + CW'(1)) == count_r) begin
          state_nxt = S_PEEK;
        end else begin
          slot     = lifo_r ? slot_inc(scan_r) : slot_dec(scan_r);
          rd_en    = 1'b1;
          rd_addr  = slot;
          scan_nxt = slot;
          k_nxt    = k_r + CW'(1);
        end
      end
      S_PEEK: begin
        rd_en     = 1'b1;
        rd_addr   = lifo_r ? slot_dec(newest_r) : oldest_r;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_word_nxt.success     = res_success_r;
    out_word_nxt.out_id      = res_id_r;
    out_word_nxt.out_payload = PAY_W'(res_pay_r);
    out_word_nxt.position    = POS_W'(res_pos_r);
    out_word_nxt.entry_count = CNT_W'(count_r);
    out_word_nxt.next_id     = (count_r == '0) ? '0 : rd_id_r;
    out_valid_nxt            = (out_valid_r && !out_ready) || load_out;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      newest_r    <= '0;
      oldest_r    <= '0;
      count_r     <= '0;
      lifo_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      newest_r    <= newest_nxt;
      oldest_r    <= oldest_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        lifo_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_r        <= scan_nxt;
    k_r           <= k_nxt;
    res_success_r <= res_success_nxt;
    res_id_r      <= res_id_nxt;
    res_pay_r     <= res_pay_nxt;
    res_pos_r     <= res_pos_nxt;
    find_id_r     <= find_id_nxt;
    if (load_out) begin
      out_word_r <= out_word_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      id_mem[newest_r]  <= cmd.item_id;
      pay_mem[newest_r] <= cmd.payload[PAYLOAD_WIDTH-1:0];
    end
    if (rd_en) begin
      rd_id_r  <= id_mem[rd_addr];
      rd_pay_r <= pay_mem[rd_addr];
    end
  end

endmodule

// File: sv/stack_or_fifo_queue.sv
// ----------------------------------------------------------------------------
// stack_or_fifo_queue
// Bounded id and payload store that works as a stack or as a FIFO.
// ----------------------------------------------------------------------------
// Each input word is a push, pull, find or clear, and each gives exactly one
// result word carrying the entry count and the id the next pull would return.
// Entries sit in a single-port ring memory of DEPTH slots. After the input
// register and the command queue, a push or clear passes the engine states
// IDLE, PEEK and DONE, and a pull passes IDLE, PULL, PEEK and DONE. A find
// walks the held entries one per cycle via the memory read port in SCAN, up to
// DEPTH of them, then PEEK and DONE. The memory needs no clearing after reset.
// ----------------------------------------------------------------------------
module stack_or_fifo_queue #(
  parameter int DEPTH         = sofq_pkg::DEPTH_DEF,
  parameter int PAYLOAD_WIDTH = sofq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  sofq_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output sofq_pkg::out_word_t out_word
);
  import sofq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          f_valid, f_ready;
  cmd_t          f_cmd;
  logic          q_valid, q_ready;
  cmd_t          q_cmd;
  logic [CW-1:0] held_count;

  sofq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  sofq_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_cmd   (f_cmd),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_cmd   (q_cmd)
  );

  sofq_back #(
    .DEPTH         (DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd_valid   (q_valid),
    .cmd_ready   (q_ready),
    .cmd         (q_cmd),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .held_count  (held_count)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_count <= CW'(DEPTH))
    else $error("entry count exceeds the store depth");

  a_pull_id_success: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.out_id != '0)) |-> out_word.success)
    else $error("removed id reported without success");

  a_peek_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_word.entry_count != '0)) |-> (out_word.next_id != '0))
    else $error("nonempty store reports a zero next id");
`endif

endmodule
